[rtl/core/vwd_pkg.sv]
// vwd_pkg: shared types and fixed field widths for the vertex weld block
// no dependencies

package vwd_pkg;

    // fixed field widths of the ports
    localparam int COORD_W  = 24;
    localparam int THRESH_W = 52;
    localparam int REMAP_W  = 10;
    localparam int TOTAL_W  = 11;

    // squared magnitude of one coordinate difference and the sum of three
    localparam int MAG_W = COORD_W;
    localparam int SQ_W  = 2 * MAG_W;
    localparam int SUM_W = SQ_W + 2;

    // one stored unique position
    typedef struct packed {
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } pos_t;

    localparam int POS_W = $bits(pos_t);

    // status of the distance pipeline toward the sequencer
    typedef struct packed {
        logic busy;
        logic hit;
    } srch_t;

endpackage

[rtl/core/vwd_ram.sv]
// vwd_ram: generic single-port-write, single-port-read ram with registered read
// no dependencies

module vwd_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/core/vwd_dist.sv]
// vwd_dist: three-stage squared distance and threshold compare pipeline
// depends on vwd_pkg

module vwd_dist #(
    parameter int IDX_W = 10
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             flush,
    input  logic                             in_valid,
    input  logic [IDX_W-1:0]                 in_idx,
    input  vwd_pkg::pos_t                    entry,
    input  vwd_pkg::pos_t                    pos,
    input  logic [vwd_pkg::THRESH_W-1:0]     threshold,
    output vwd_pkg::srch_t                   status,
    output logic [IDX_W-1:0]                 hit_idx
);

    localparam int CW = vwd_pkg::COORD_W;
    localparam int MW = vwd_pkg::MAG_W;
    localparam int QW = vwd_pkg::SQ_W;
    localparam int SW = vwd_pkg::SUM_W;
    localparam int TW = vwd_pkg::THRESH_W;

    logic              v_a_reg, v_a_next;
    logic              v_b_reg, v_b_next;
    logic              v_c_reg, v_c_next;
    logic [IDX_W-1:0]  idx_a_reg, idx_b_reg, idx_c_reg;
    logic [MW-1:0]     mag_x_reg, mag_y_reg, mag_z_reg;
    logic [MW-1:0]     mag_x_next, mag_y_next, mag_z_next;
    logic [QW-1:0]     sq_x_reg, sq_y_reg, sq_z_reg;
    logic              hit_c_reg, hit_c_next;
    logic [SW-1:0]     sum;

    // magnitude of a signed difference, which always fits the coordinate width
    function automatic logic [MW-1:0] abs_diff(logic signed [CW-1:0] a,
                                               logic signed [CW-1:0] b);
        logic signed [CW:0] d;
        logic signed [CW:0] m;
        d = (CW+1)'(a) - (CW+1)'(b);
        m = d[CW] ? -d : d;
        return m[MW-1:0];
    endfunction

    // stage a: coordinate differences
    always_comb begin
        mag_x_next = abs_diff(pos.x, entry.x);
        mag_y_next = abs_diff(pos.y, entry.y);
        mag_z_next = abs_diff(pos.z, entry.z);
    end

    // stage c: sum of squares against threshold
    always_comb begin
        sum        = SW'(sq_x_reg) + SW'(sq_y_reg) + SW'(sq_z_reg);
        hit_c_next = TW'(sum) < threshold;
    end

    // stage valids, cleared on flush
    always_comb begin
        v_a_next = in_valid && !flush;
        v_b_next = v_a_reg && !flush;
        v_c_next = v_b_reg && !flush;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_a_reg <= 1'b0;
            v_b_reg <= 1'b0;
            v_c_reg <= 1'b0;
        end else begin
            v_a_reg <= v_a_next;
            v_b_reg <= v_b_next;
            v_c_reg <= v_c_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        idx_a_reg <= in_idx;
        mag_x_reg <= mag_x_next;
        mag_y_reg <= mag_y_next;
        mag_z_reg <= mag_z_next;
        idx_b_reg <= idx_a_reg;
        sq_x_reg  <= mag_x_reg * mag_x_reg;
        sq_y_reg  <= mag_y_reg * mag_y_reg;
        sq_z_reg  <= mag_z_reg * mag_z_reg;
        idx_c_reg <= idx_b_reg;
        hit_c_reg <= hit_c_next;
    end

    assign status.busy = v_a_reg || v_b_reg || v_c_reg;
    assign status.hit  = v_c_reg && hit_c_reg;
    assign hit_idx     = idx_c_reg;

endmodule

[rtl/core/vertex_weld_dedup.sv]
// vertex_weld_dedup: vertex welding by squared distance threshold, top level
// depends on vwd_pkg, vwd_ram, vwd_dist
//
//  channel   direction  signals
//  s_        in         s_valid s_ready s_pos_x s_pos_y s_pos_z s_first_of_mesh
//  m_        out        m_valid m_ready m_remap_index m_is_new m_table_full
//                       m_unique_total
//  cfg_      in         cfg_wr_en cfg_wr_data (threshold_sq)
//
// with the output register free, a vertex that misses holds the sequencer
// while all unique-count entries are read and compared; a match at entry j
// ends the scan early. the table ram delivers one stored entry per cycle to the
// three-stage distance pipeline, and a match stops the scan once its hit
// reaches stage c. no clearing pass after reset.
// a new vertex is taken whenever the sequencer is idle, even while a result
// still waits in the output register; the final step waits for that register.

module vertex_weld_dedup #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [vwd_pkg::THRESH_W-1:0]   cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [vwd_pkg::COORD_W-1:0] s_pos_x,
    input  logic signed [vwd_pkg::COORD_W-1:0] s_pos_y,
    input  logic signed [vwd_pkg::COORD_W-1:0] s_pos_z,
    input  logic                           s_first_of_mesh,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [vwd_pkg::REMAP_W-1:0]    m_remap_index,
    output logic                           m_is_new,
    output logic                           m_table_full,
    output logic [vwd_pkg::TOTAL_W-1:0]    m_unique_total
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int RW = vwd_pkg::REMAP_W;
    localparam int TW = vwd_pkg::TOTAL_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]                   state_reg, state_next;
    logic [vwd_pkg::THRESH_W-1:0] thresh_reg;
    vwd_pkg::pos_t                pos_reg;
    logic [CW-1:0]                count_reg, count_next;
    logic [CW-1:0]                rd_cnt_reg, rd_cnt_next;
    logic                         rd_v_reg, rd_v_next;
    logic [AW-1:0]                rd_idx_reg;
    logic                         found_reg, found_next;
    logic [AW-1:0]                match_reg, match_next;
    logic                         m_valid_reg;
    logic [RW-1:0]                remap_reg;
    logic                         is_new_reg, full_reg;
    logic [TW-1:0]                total_reg;

    logic                         s_take;
    logic                         issue;
    logic                         flush;
    logic                         fin_go;
    logic                         has_room;
    logic                         wr_new;
    vwd_pkg::pos_t                entry;
    vwd_pkg::srch_t               srch;
    logic [AW-1:0]                hit_idx;
    logic [AW-1:0]                remap_sel;
    logic [CW-1:0]                total_sel;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_take  = s_valid && s_ready;

    // scan control: one read per cycle below the unique count
    assign issue    = (state_reg == ST_SCAN) && (rd_cnt_reg != count_reg) && !srch.hit;
    assign flush    = srch.hit;
    assign fin_go   = (state_reg == ST_FIN) && (!m_valid_reg || m_ready);
    assign has_room = count_reg < DEPTH_C;
    assign wr_new   = fin_go && !found_reg && has_room;

    // sequencer
    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        rd_cnt_next = rd_cnt_reg;
        rd_v_next   = issue;
        found_next  = found_reg;
        match_next  = match_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_take) begin
                    state_next  = ST_SCAN;
                    rd_cnt_next = '0;
                    found_next  = 1'b0;
                    if (s_first_of_mesh) begin
                        count_next = '0;
                    end
                end
            end
            ST_SCAN: begin
                if (issue) begin
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                end
                if (srch.hit) begin
                    found_next = 1'b1;
                    match_next = hit_idx;
                    state_next = ST_FIN;
                end else if (rd_cnt_reg == count_reg && !rd_v_reg && !srch.busy) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (fin_go) begin
                    state_next = ST_IDLE;
                    if (wr_new) begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            rd_cnt_reg <= '0;
            rd_v_reg   <= 1'b0;
            found_reg  <= 1'b0;
            thresh_reg <= '0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rd_cnt_reg <= rd_cnt_next;
            rd_v_reg   <= rd_v_next;
            found_reg  <= found_next;
            if (cfg_wr_en) begin
                thresh_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        match_reg  <= match_next;
        rd_idx_reg <= rd_cnt_reg[AW-1:0];
        if (s_take) begin
            pos_reg.x <= s_pos_x;
            pos_reg.y <= s_pos_y;
            pos_reg.z <= s_pos_z;
        end
    end

    // unique position table
    vwd_ram #(
        .WIDTH (vwd_pkg::POS_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_new),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (pos_reg),
        .rd_en   (issue),
        .rd_addr (rd_cnt_reg[AW-1:0]),
        .rd_data (entry)
    );

    // distance pipeline
    vwd_dist #(
        .IDX_W (AW)
    ) u_dist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .flush     (flush),
        .in_valid  (rd_v_reg),
        .in_idx    (rd_idx_reg),
        .entry     (entry),
        .pos       (pos_reg),
        .threshold (thresh_reg),
        .status    (srch),
        .hit_idx   (hit_idx)
    );

    // result selection
    always_comb begin
        if (found_reg) begin
            remap_sel = match_reg;
            total_sel = count_reg;
        end else if (has_room) begin
            remap_sel = count_reg[AW-1:0];
            total_sel = count_reg + 1'b1;
        end else begin
            remap_sel = '0;
            total_sel = count_reg;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fin_go) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fin_go) begin
            remap_reg  <= RW'(remap_sel);
            is_new_reg <= !found_reg && has_room;
            full_reg   <= !found_reg && !has_room;
            total_reg  <= TW'(total_sel);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_remap_index  = remap_reg;
    assign m_is_new       = is_new_reg;
    assign m_table_full   = full_reg;
    assign m_unique_total = total_reg;

endmodule
